>>> design/assert_macros.svh
// Assertion helpers used by the store buffer top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define SBUF_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, checked outside reset.
`define SBUF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define SBUF_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)
`define SBUF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

>>> design/sbuf_pkg.sv
package sbuf_pkg;

  // Buffer geometry
  localparam int unsigned DEPTH  = 8;
  localparam int unsigned PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

  // Field widths
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned ADDR_W   = 31;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned ROB_W    = 5;
  localparam int unsigned AGE_W    = 8;
  localparam int unsigned LAT_W    = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OCC_W    = 4;

  // Decoupling queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  localparam logic [AGE_W-1:0] AGE_MAX   = '1;
  localparam logic [AGE_W-1:0] AGE_FIRST = AGE_W'(1);
  localparam logic [LAT_W-1:0] LAT_RESET = LAT_W'(3);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ENQUEUE = 2'd0,
    FUNC_AGE     = 2'd1,
    FUNC_DRAIN   = 2'd2,
    FUNC_FLUSH   = 2'd3
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_NOT_READY = 2'd2
  } status_e;

  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic [ADDR_W-1:0]        store_address;
    logic signed [DATA_W-1:0] store_value;
    logic [ROB_W-1:0]         rob_index;
  } req_t;

  typedef struct packed {
    logic                     mem_write_valid;
    logic [ADDR_W-1:0]        mem_address;
    logic signed [DATA_W-1:0] mem_value;
    logic [ROB_W-1:0]         done_rob_index;
    logic [STATUS_W-1:0]      status;
    logic [OCC_W-1:0]         occupancy;
  } rsp_t;

  typedef struct packed {
    func_e                    op;
    logic [ADDR_W-1:0]        address;
    logic signed [DATA_W-1:0] value;
    logic [ROB_W-1:0]         rob;
  } cmd_t;

endpackage

>>> design/sbuf_in_if.sv
interface sbuf_in_if;
  logic              valid;
  logic              ready;
  sbuf_pkg::req_t    payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> design/sbuf_out_if.sv
interface sbuf_out_if;
  logic              valid;
  logic              ready;
  sbuf_pkg::rsp_t    payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> design/sbuf_cfg_if.sv
interface sbuf_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [sbuf_pkg::LAT_W-1:0]    data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> design/store_buffer_fixed_latency_drain.sv
// Store buffer with fixed drain latency.
// req_i carries one operation per transaction: enqueue a store, age all
// held entries, try to drain the oldest entry, or flush the buffer.
// rsp_o returns exactly one result per request, in order: the drained
// memory write (address, data, reorder-buffer index), a status code and
// the occupancy after the operation. An enqueue to a full buffer is
// rejected with a full status; a drain of an empty or too-young head
// reports not-ready. cfg_i writes the drain latency (reset value LAT_RESET) and
// is always ready; write it only while no request is in flight.
// From request acceptance to result valid, a transaction passes the front
// register, two-entry decoupling queue and back-end result register.
// Throughput: one transaction per cycle while rsp_o does not stall; the
// back end updates the entry array and its ages with each result.
// Reset clears pointers, fill count, queue and output valid; entry contents
// are not cleared. When rsp_o stalls, the result register holds, the queue
// fills, and req_i.ready drops once front register and queue are full.
`include "assert_macros.svh"

module store_buffer_fixed_latency_drain (
  input  logic        clk_i,
  input  logic        rst_ni,
  sbuf_in_if.sink     req_i,
  sbuf_out_if.source  rsp_o,
  sbuf_cfg_if.sink    cfg_i
);

  logic           f_valid;
  logic           f_ready;
  sbuf_pkg::cmd_t f_cmd;
  logic           b_valid;
  logic           b_ready;
  sbuf_pkg::cmd_t b_cmd;
  logic           rsp_full;
  logic           occ_at_depth;
  logic           rsp_failed;
  logic           rsp_quiet;

  // Accept and classify requests
  sbuf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req         (req_i),
    .cmd_valid_o (f_valid),
    .cmd_ready_i (f_ready),
    .cmd_o       (f_cmd)
  );

  // Decouple front and back
  sbuf_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (f_valid),
    .in_ready_o  (f_ready),
    .in_cmd_i    (f_cmd),
    .out_valid_o (b_valid),
    .out_ready_i (b_ready),
    .out_cmd_o   (b_cmd)
  );

  // Execute against the entry array
  sbuf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (b_valid),
    .cmd_ready_o (b_ready),
    .cmd_i       (b_cmd),
    .cfg         (cfg_i),
    .rsp         (rsp_o)
  );

  // Qualify result fields for the checks
  assign rsp_full     = rsp_o.valid && (rsp_o.payload.status == sbuf_pkg::STATUS_FULL);
  assign occ_at_depth = rsp_o.payload.occupancy == sbuf_pkg::OCC_W'(sbuf_pkg::DEPTH);
  assign rsp_failed   = rsp_o.valid && (rsp_o.payload.status != sbuf_pkg::STATUS_OK);
  assign rsp_quiet    = !rsp_o.payload.mem_write_valid && (rsp_o.payload.mem_address == '0)
                        && (rsp_o.payload.mem_value == '0)
                        && (rsp_o.payload.done_rob_index == '0);

  // A rejected enqueue only happens on a full buffer
  `SBUF_ASSERT_IMPLY(a_full_occ, clk_i, rst_ni, rsp_full, occ_at_depth, "full status, not full")
  // A failed operation carries no memory write
  `SBUF_ASSERT_IMPLY(a_fail_quiet, clk_i, rst_ni, rsp_failed, rsp_quiet, "failed op has a write")

endmodule

>>> design/sbuf_front.sv
module sbuf_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  sbuf_in_if.sink        req,
  output logic           cmd_valid_o,
  input  logic           cmd_ready_i,
  output sbuf_pkg::cmd_t cmd_o
);

  logic           vld_q;
  sbuf_pkg::cmd_t cmd_q;
  sbuf_pkg::cmd_t cmd_d;
  logic           accept;

  // Take a new transaction when the holding register is empty or drains now
  assign req.ready = !vld_q || cmd_ready_i;
  assign accept    = req.valid && req.ready;

  // Classify the operation code and strip fields the operation ignores
  always_comb begin
    cmd_d.op      = sbuf_pkg::func_e'(req.payload.func);
    cmd_d.address = '0;
    cmd_d.value   = '0;
    cmd_d.rob     = '0;
    case (cmd_d.op)
      sbuf_pkg::FUNC_ENQUEUE: begin
        cmd_d.address = req.payload.store_address;
        cmd_d.value   = req.payload.store_value;
        cmd_d.rob     = req.payload.rob_index;
      end
      default: ;
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (accept) begin
      vld_q <= 1'b1;
    end else if (cmd_ready_i) begin
      vld_q <= 1'b0;
    end
  end

  // Capture payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_d;
    end
  end

  assign cmd_valid_o = vld_q;
  assign cmd_o       = cmd_q;

endmodule

>>> design/sbuf_queue.sv
module sbuf_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  sbuf_pkg::cmd_t in_cmd_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output sbuf_pkg::cmd_t out_cmd_o
);

  sbuf_pkg::cmd_t                   slot_q [sbuf_pkg::QUEUE_DEPTH];
  logic [sbuf_pkg::QPTR_W-1:0]      wr_ptr_q;
  logic [sbuf_pkg::QPTR_W-1:0]      rd_ptr_q;
  logic [sbuf_pkg::QCNT_W-1:0]      cnt_q;
  logic                             push;
  logic                             pop;

  assign in_ready_o  = cnt_q != sbuf_pkg::QCNT_W'(sbuf_pkg::QUEUE_DEPTH);
  assign out_valid_o = cnt_q != '0;
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;
  assign out_cmd_o   = slot_q[rd_ptr_q];

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == sbuf_pkg::QPTR_W'(sbuf_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == sbuf_pkg::QPTR_W'(sbuf_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= in_cmd_i;
    end
  end

endmodule

>>> design/sbuf_back.sv
module sbuf_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  output logic           cmd_ready_o,
  input  sbuf_pkg::cmd_t cmd_i,
  sbuf_cfg_if.sink       cfg,
  sbuf_out_if.source     rsp
);

  logic [sbuf_pkg::ADDR_W-1:0]        addr_q  [sbuf_pkg::DEPTH];
  logic signed [sbuf_pkg::DATA_W-1:0] value_q [sbuf_pkg::DEPTH];
  logic [sbuf_pkg::ROB_W-1:0]         rob_q   [sbuf_pkg::DEPTH];
  logic [sbuf_pkg::AGE_W-1:0]         age_q   [sbuf_pkg::DEPTH];

  logic [sbuf_pkg::PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [sbuf_pkg::PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [sbuf_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic [sbuf_pkg::LAT_W-1:0] lat_q;
  logic                       out_vld_q;
  sbuf_pkg::rsp_t             out_q, out_d;

  logic                       fire;
  logic                       full;
  logic                       head_ready;
  logic                       enq_we;
  logic                       age_all;
  logic [sbuf_pkg::DEPTH-1:0] occupied;

  function automatic logic [sbuf_pkg::PTR_W-1:0] next_ptr(
    input logic [sbuf_pkg::PTR_W-1:0] p
  );
    return (p == sbuf_pkg::PTR_W'(sbuf_pkg::DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign cmd_ready_o = !out_vld_q || rsp.ready;
  assign fire        = cmd_valid_i && cmd_ready_o;
  assign full        = cnt_q == sbuf_pkg::CNT_W'(sbuf_pkg::DEPTH);
  assign head_ready  = (cnt_q != '0) && (age_q[rd_ptr_q] >= lat_q);

  // Mark entries between the read pointer and the fill count as occupied
  always_comb begin
    logic [sbuf_pkg::CNT_W-1:0] off;
    off = '0;
    for (int i = 0; i < sbuf_pkg::DEPTH; i++) begin
      if (sbuf_pkg::PTR_W'(i) >= rd_ptr_q) begin
        off = sbuf_pkg::CNT_W'(i) - sbuf_pkg::CNT_W'(rd_ptr_q);
      end else begin
        off = sbuf_pkg::CNT_W'(i) + sbuf_pkg::CNT_W'(sbuf_pkg::DEPTH)
            - sbuf_pkg::CNT_W'(rd_ptr_q);
      end
      occupied[i] = off < cnt_q;
    end
  end

  // Carry out the operation and build the result
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    enq_we   = 1'b0;
    age_all  = 1'b0;
    out_d    = '0;
    out_d.status = sbuf_pkg::STATUS_OK;
    case (cmd_i.op)
      sbuf_pkg::FUNC_ENQUEUE: begin
        if (full) begin
          out_d.status = sbuf_pkg::STATUS_FULL;
        end else begin
          enq_we   = 1'b1;
          wr_ptr_d = next_ptr(wr_ptr_q);
          cnt_d    = cnt_q + 1'b1;
        end
      end
      sbuf_pkg::FUNC_AGE: begin
        age_all = 1'b1;
      end
      sbuf_pkg::FUNC_DRAIN: begin
        if (head_ready) begin
          out_d.mem_write_valid = 1'b1;
          out_d.mem_address     = addr_q[rd_ptr_q];
          out_d.mem_value       = value_q[rd_ptr_q];
          out_d.done_rob_index  = rob_q[rd_ptr_q];
          rd_ptr_d              = next_ptr(rd_ptr_q);
          cnt_d                 = cnt_q - 1'b1;
        end else begin
          out_d.status = sbuf_pkg::STATUS_NOT_READY;
        end
      end
      sbuf_pkg::FUNC_FLUSH: begin
        wr_ptr_d = '0;
        rd_ptr_d = '0;
        cnt_d    = '0;
      end
      default: ;
    endcase
    out_d.occupancy = sbuf_pkg::OCC_W'(cnt_d);
  end

  // Hold control state, latency register and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q  <= '0;
      rd_ptr_q  <= '0;
      cnt_q     <= '0;
      lat_q     <= sbuf_pkg::LAT_RESET;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        lat_q <= cfg.data;
      end
      if (fire) begin
        wr_ptr_q  <= wr_ptr_d;
        rd_ptr_q  <= rd_ptr_d;
        cnt_q     <= cnt_d;
        out_vld_q <= 1'b1;
      end else if (rsp.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Write result register, entries and ages
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= out_d;
      if (enq_we) begin
        addr_q[wr_ptr_q]  <= cmd_i.address;
        value_q[wr_ptr_q] <= cmd_i.value;
        rob_q[wr_ptr_q]   <= cmd_i.rob;
      end
      for (int i = 0; i < sbuf_pkg::DEPTH; i++) begin
        if (enq_we && (wr_ptr_q == sbuf_pkg::PTR_W'(i))) begin
          age_q[i] <= sbuf_pkg::AGE_FIRST;
        end else if (age_all && occupied[i] && (age_q[i] != sbuf_pkg::AGE_MAX)) begin
          age_q[i] <= age_q[i] + 1'b1;
        end
      end
    end
  end

  assign cfg.ready   = 1'b1;
  assign rsp.valid   = out_vld_q;
  assign rsp.payload = out_q;

endmodule
